FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// pre holds -> post holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// pre holds -> post holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

FILE: rtl/kfa_pkg.sv
// ---------------------------------------------------------------------------
// kfa_pkg
// Types and field layout shared by the keyframe animation sequencer.
// ---------------------------------------------------------------------------
package kfa_pkg;

   // request field widths and positions in req_tdata
   localparam int CMD_W      = 3;
   localparam int MODEL_W    = 4;
   localparam int INST_W     = 6;
   localparam int FRAMES_W   = 16;
   localparam int PCOUNT_W   = 8;
   localparam int PBASE_W    = 16;
   localparam int TBASE_W    = 16;
   localparam int MESH_W     = 6;
   localparam int COUNT_W    = 7;

   localparam int CMD_LSB    = 0;
   localparam int MODEL_LSB  = CMD_LSB + CMD_W;
   localparam int INST_LSB   = MODEL_LSB + MODEL_W;
   localparam int FRAMES_LSB = INST_LSB + INST_W;
   localparam int PCOUNT_LSB = FRAMES_LSB + FRAMES_W;
   localparam int PBASE_LSB  = PCOUNT_LSB + PCOUNT_W;
   localparam int TBASE_LSB  = PBASE_LSB + PBASE_W;
   localparam int MESH_LSB   = TBASE_LSB + TBASE_W;
   localparam int COUNT_LSB  = MESH_LSB + MESH_W;
   localparam int REQ_FIELDS_W = COUNT_LSB + COUNT_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;

   // response: status, paused, active, pose_now, transform_index, root_index
   localparam int POSE_W       = 8;
   localparam int INDEX_W      = 16;
   localparam int RSP_FIELDS_W = 3 + POSE_W + 2 * INDEX_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_START   = 3'd0,
      CMD_PAUSE   = 3'd1,
      CMD_UNPAUSE = 3'd2,
      CMD_DEACT   = 3'd3,
      CMD_TICK    = 3'd4,
      CMD_QUERY   = 3'd5,
      CMD_SETCNT  = 3'd6
   } kfa_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOCATE,
      ST_APPLY,
      ST_TICK,
      ST_FINISH
   } kfa_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture the request transfer
      logic locate;     // resolve entry, act on commands needing no read
      logic apply;      // finish read-modify-write or query
      logic tick_start; // clear the walk counter
      logic tick_step;  // walk one entry
      logic respond;    // move result into the response register
   } kfa_ctrl_type;

   // datapath -> controller
   typedef struct packed {
      kfa_cmd_type cmd;
      logic        tick_more;
      logic        rsp_free;
   } kfa_stat_type;

endpackage

FILE: rtl/kfa_ctrl.sv
// ---------------------------------------------------------------------------
// kfa_ctrl
// Command sequencer: accepts a request, steps the datapath through it and
// hands the result to the response register.
// ---------------------------------------------------------------------------
module kfa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  kfa_pkg::kfa_stat_type stat,
   output kfa_pkg::kfa_ctrl_type ctrl
);
   import kfa_pkg::*;

   kfa_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      ctrl       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctrl.load = 1'b1;
               state_in  = ST_LOCATE;
            end
         end
         ST_LOCATE: begin
            ctrl.locate = 1'b1;
            case (stat.cmd) inside
               CMD_UNPAUSE, CMD_QUERY: state_in = ST_APPLY;
               CMD_TICK: begin
                  ctrl.tick_start = 1'b1;
                  state_in        = ST_TICK;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_APPLY: begin
            ctrl.apply = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_TICK: begin
            // last writeback lands in the cycle the walk runs out
            ctrl.tick_step = 1'b1;
            if (!stat.tick_more) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.rsp_free) begin
               ctrl.respond = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/kfa_datapath.sv
// ---------------------------------------------------------------------------
// kfa_datapath
// Instance table, group offsets, tick walker and response register.
// ---------------------------------------------------------------------------
module kfa_datapath #(
   parameter int MAX_INSTANCES = 64,
   parameter int MAX_MODELS    = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [kfa_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                               req_tlast,
   input  kfa_pkg::kfa_ctrl_type              ctrl,
   output kfa_pkg::kfa_stat_type              stat,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [kfa_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import kfa_pkg::*;

   localparam int AW = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
   localparam int TW = $clog2(MAX_INSTANCES + 1);
   localparam int MW = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;
   localparam logic [8:0]    INST_LIMIT  = 9'(MAX_INSTANCES);
   localparam logic [6:0]    MODEL_LIMIT = 7'(MAX_MODELS);
   localparam logic [MW-1:0] CURSOR_LAST = MW'(MAX_MODELS - 1);
   localparam logic [TW-1:0] TOTAL_LIMIT = TW'(MAX_INSTANCES);

   // countdown here is only meaningful while the entry's live bit is set;
   // a cleared live bit stands for a countdown of minus one
   typedef struct packed {
      logic [FRAMES_W-1:0] count;
      logic [FRAMES_W-1:0] reload;
      logic [POSE_W-1:0]   total;
      logic [POSE_W-1:0]   pose;
      logic [MESH_W-1:0]   mesh;
      logic [INDEX_W-1:0]  xform;
      logic [INDEX_W-1:0]  root;
   } entry_type;

   // captured request
   logic [REQ_FIELDS_W-1:0] item_ff;
   logic                    last_ff;

   logic [CMD_W-1:0]    f_cmd;
   logic [MODEL_W-1:0]  f_model;
   logic [INST_W-1:0]   f_inst;
   logic [FRAMES_W-1:0] f_frames;
   logic [PCOUNT_W-1:0] f_pcount;
   logic [PBASE_W-1:0]  f_pbase;
   logic [TBASE_W-1:0]  f_tbase;
   logic [MESH_W-1:0]   f_mesh;
   logic [COUNT_W-1:0]  f_count;
   kfa_cmd_type         cmd;

   assign f_cmd    = item_ff[CMD_LSB    +: CMD_W];
   assign f_model  = item_ff[MODEL_LSB  +: MODEL_W];
   assign f_inst   = item_ff[INST_LSB   +: INST_W];
   assign f_frames = item_ff[FRAMES_LSB +: FRAMES_W];
   assign f_pcount = item_ff[PCOUNT_LSB +: PCOUNT_W];
   assign f_pbase  = item_ff[PBASE_LSB  +: PBASE_W];
   assign f_tbase  = item_ff[TBASE_LSB  +: TBASE_W];
   assign f_mesh   = item_ff[MESH_LSB   +: MESH_W];
   assign f_count  = item_ff[COUNT_LSB  +: COUNT_W];
   assign cmd      = kfa_cmd_type'(f_cmd);

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         item_ff <= req_tdata[REQ_FIELDS_W-1:0];
         last_ff <= req_tlast;
      end
   end

   // group offsets and set-count bookkeeping
   logic [6:0]    model_offset [MAX_MODELS];
   logic [7:0]    offset_sum_ff, offset_sum_in;
   logic [MW-1:0] cursor_ff, cursor_in;
   logic [TW-1:0] total_ff, total_in;
   logic [8:0]    sum_wide;
   logic [7:0]    sum_sat;
   logic          setcnt_go;

   assign setcnt_go = ctrl.locate && (cmd == CMD_SETCNT);
   assign sum_wide  = {1'b0, offset_sum_ff} + {2'b0, f_count};
   assign sum_sat   = sum_wide[8] ? 8'hFF : sum_wide[7:0];

   always_comb begin
      offset_sum_in = offset_sum_ff;
      cursor_in     = cursor_ff;
      total_in      = total_ff;
      if (setcnt_go) begin
         total_in  = ({1'b0, sum_sat} > INST_LIMIT) ? TOTAL_LIMIT : TW'(sum_sat);
         cursor_in = (cursor_ff == CURSOR_LAST) ? '0 : cursor_ff + 1'b1;
         offset_sum_in = sum_sat;
         if (last_ff) begin
            offset_sum_in = '0;
            cursor_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (setcnt_go) begin
         model_offset[cursor_ff] <= offset_sum_ff[7] ? 7'd127 : offset_sum_ff[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_sum_ff <= '0;
         cursor_ff     <= '0;
         total_ff      <= '0;
      end else begin
         offset_sum_ff <= offset_sum_in;
         cursor_ff     <= cursor_in;
         total_ff      <= total_in;
      end
   end

   // entry address
   logic          model_ok;
   logic [MW-1:0] model_idx;
   logic [6:0]    base;
   logic [7:0]    entry_sum;
   logic          entry_ok;
   logic [AW-1:0] entry_addr;

   assign model_ok   = {3'b0, f_model} < MODEL_LIMIT;
   assign model_idx  = MW'({3'b0, f_model});
   assign base       = model_ok ? model_offset[model_idx] : 7'd0;
   assign entry_sum  = {1'b0, base} + {2'b0, f_inst};
   assign entry_ok   = model_ok && ({1'b0, entry_sum} < INST_LIMIT);
   assign entry_addr = entry_sum[AW-1:0];

   logic [AW-1:0] entry_ff;
   logic          entry_ok_ff;

   always_ff @(posedge clock) begin
      if (ctrl.locate) begin
         entry_ff    <= entry_addr;
         entry_ok_ff <= entry_ok;
      end
   end

   // per-entry flags
   logic [MAX_INSTANCES-1:0] live_ff, live_in;
   logic [MAX_INSTANCES-1:0] has_pose_ff, has_pose_in;

   // tick walk
   logic [TW-1:0] tick_cnt_ff, tick_cnt_in;
   logic          tick_more;
   logic          tick_rd;
   logic          tick_pend_ff;
   logic [AW-1:0] tick_addr_ff;

   assign tick_more = tick_cnt_ff < total_ff;
   assign tick_rd   = ctrl.tick_step && tick_more;

   always_comb begin
      tick_cnt_in = tick_cnt_ff;
      if (ctrl.tick_start) begin
         tick_cnt_in = '0;
      end else if (tick_rd) begin
         tick_cnt_in = tick_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_cnt_ff  <= '0;
         tick_pend_ff <= 1'b0;
      end else begin
         tick_cnt_ff  <= tick_cnt_in;
         tick_pend_ff <= tick_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_rd) begin
         tick_addr_ff <= tick_cnt_ff[AW-1:0];
      end
   end

   // entry memory: one write and one registered read per cycle
   entry_type     entry_ram [MAX_INSTANCES];
   entry_type     rd_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;

   assign rd_en   = (ctrl.locate && entry_ok) || tick_rd;
   assign rd_addr = ctrl.tick_step ? tick_cnt_ff[AW-1:0] : entry_addr;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= entry_ram[rd_addr];
      end
      if (wr_en) begin
         entry_ram[wr_addr] <= wr_data;
      end
   end

   // start: load at the last pose
   logic [POSE_W-1:0] start_last;
   logic [13:0]       start_step;
   entry_type         start_word;

   assign start_last = f_pcount - 8'd1;
   assign start_step = start_last * f_mesh;

   always_comb begin
      start_word.count  = f_frames;
      start_word.reload = f_frames;
      start_word.total  = f_pcount;
      start_word.pose   = start_last;
      start_word.mesh   = f_mesh;
      start_word.xform  = f_tbase + {2'b0, start_step};
      start_word.root   = f_pbase + {8'b0, start_last};
   end

   // tick: count down, on underflow reload and step down or wrap the pose
   logic [POSE_W-1:0] wrap_pose;
   logic [13:0]       wrap_step;
   entry_type         tick_word;

   assign wrap_pose = rd_ff.total - 8'd1;
   assign wrap_step = wrap_pose * rd_ff.mesh;

   always_comb begin
      tick_word = rd_ff;
      if (rd_ff.count == '0) begin
         tick_word.count = rd_ff.reload;
         if (rd_ff.pose == '0) begin
            tick_word.pose  = wrap_pose;
            tick_word.xform = rd_ff.xform + {2'b0, wrap_step};
            tick_word.root  = rd_ff.root + {8'b0, wrap_pose};
         end else begin
            tick_word.pose  = rd_ff.pose - 8'd1;
            tick_word.xform = rd_ff.xform - {10'b0, rd_ff.mesh};
            tick_word.root  = rd_ff.root - 16'd1;
         end
      end else begin
         tick_word.count = rd_ff.count - 16'd1;
      end
   end

   // write port and flag updates
   logic apply_ok;
   assign apply_ok = ctrl.apply && entry_ok_ff;

   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = entry_addr;
      wr_data     = rd_ff;
      live_in     = live_ff;
      has_pose_in = has_pose_ff;

      if (ctrl.locate && entry_ok) begin
         case (cmd)
            CMD_START: begin
               wr_en                   = 1'b1;
               wr_data                 = start_word;
               live_in[entry_addr]     = 1'b1;
               has_pose_in[entry_addr] = 1'b1;
            end
            CMD_PAUSE: live_in[entry_addr] = 1'b0;
            CMD_DEACT: begin
               live_in[entry_addr]     = 1'b0;
               has_pose_in[entry_addr] = 1'b0;
            end
            default: ;
         endcase
      end

      if (apply_ok && (cmd == CMD_UNPAUSE)) begin
         wr_en             = 1'b1;
         wr_addr           = entry_ff;
         wr_data.count     = rd_ff.reload;
         live_in[entry_ff] = 1'b1;
      end

      if (tick_pend_ff && live_ff[tick_addr_ff]) begin
         wr_en   = 1'b1;
         wr_addr = tick_addr_ff;
         wr_data = tick_word;
      end

      if (setcnt_go && last_ff) begin
         live_in     = '0;
         has_pose_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff     <= '0;
         has_pose_ff <= '0;
      end else begin
         live_ff     <= live_in;
         has_pose_ff <= has_pose_in;
      end
   end

   // result assembly: {root, transform, pose, active, paused, status}
   logic [RSP_FIELDS_W-1:0] res_ff, res_in;

   always_comb begin
      res_in = res_ff;
      if (ctrl.load) begin
         res_in = '0;
      end else if (setcnt_go && last_ff) begin
         res_in[0] = {1'b0, sum_sat} >= INST_LIMIT;
      end else if (apply_ok && (cmd == CMD_QUERY)) begin
         res_in = {rd_ff.root, rd_ff.xform, rd_ff.pose,
                   has_pose_ff[entry_ff], !live_ff[entry_ff], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.respond) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.respond) begin
         rsp_data_ff <= {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}}, res_ff};
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_tdata      = rsp_data_ff;
   assign stat.cmd       = cmd;
   assign stat.tick_more = tick_more;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_tready;

endmodule

FILE: rtl/keyframe_animation_sequencer.sv
// ---------------------------------------------------------------------------
// keyframe_animation_sequencer
// Per-instance keyframe pose stepping with grouped instance addressing.
// ---------------------------------------------------------------------------
// One request is worked at a time and every request returns exactly one
// response. Start, pause, deactivate, set-count and the unused command pass
// through the locate and finish states; unpause and query also pass through
// the apply state, since they read the entry memory and act on the registered
// data. A tick runs the walker, which reads one entry per cycle from the
// single-read, single-write entry memory and writes the updated entry back
// in the next cycle, so the memory port sets the pace of the walk. The
// controller returns to idle as the response register loads, and only then
// accepts the next request transfer. The response register frees the request
// side while a result waits; a new result is held back only while the
// previous one is still untaken.
module keyframe_animation_sequencer #(
   parameter int MAX_INSTANCES = 64,
   parameter int MAX_MODELS    = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata, from bit 0: command[3], model_id[4], instance_id[6],
   // frames_between[16], pose_count[8], pose_base[16], transform_base[16],
   // mesh_count[6], model_instances[7], zero pad[6]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [kfa_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   // rsp_tdata, from bit 0: status[1], paused[1], active[1], pose_now[8],
   // transform_index[16], root_index[16], zero pad[5]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [kfa_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import kfa_pkg::*;

   `include "assert_macros.svh"

   kfa_ctrl_type ctrl_bus;
   kfa_stat_type stat_bus;

   kfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat_bus),
      .ctrl       (ctrl_bus)
   );

   kfa_datapath #(
      .MAX_INSTANCES (MAX_INSTANCES),
      .MAX_MODELS    (MAX_MODELS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .ctrl       (ctrl_bus),
      .stat       (stat_bus),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted while busy")
   `ASSERT_IMPLIES(a_respond_into_free, clock, reset, ctrl_bus.respond, stat_bus.rsp_free, "response register overwritten")
   `ASSERT_IMPLIES(a_rsp_from_respond, clock, reset, $rose(rsp_tvalid), $past(ctrl_bus.respond), "response raised without a result")
   `ASSERT_IMPLIES(a_one_action, clock, reset, ctrl_bus.locate || ctrl_bus.apply || ctrl_bus.tick_step, !req_tready, "datapath stepped while idle")

endmodule

FILE: tb/tb_keyframe_animation_sequencer.sv
// ----------------------------------------------------------------------------
// Keyframe animation sequencer testbench
// Streams commands into the sequencer, predicts every response from a local
// model of the instance table and compares each response field by field.
// Directed tests cover group building, start, pose stepping with wrap,
// pause controls, out-of-range addressing, the unused command and one long
// response hold-off. A random phase then runs scenes of group builds
// followed by mixed commands, with idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_keyframe_animation_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   import kfa_pkg::*;

   localparam int MAX_ENTRIES = 64;
   localparam int MAX_GROUPS  = 16;
   localparam int RANDOM_REQS = 1700;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

   typedef struct {
      logic [CMD_W-1:0]    command;
      logic [MODEL_W-1:0]  model_id;
      logic [INST_W-1:0]   inst;
      logic [FRAMES_W-1:0] frames;
      logic [PCOUNT_W-1:0] pose_count;
      logic [PBASE_W-1:0]  pose_base;
      logic [TBASE_W-1:0]  transform_base;
      logic [MESH_W-1:0]   mesh;
      logic [COUNT_W-1:0]  instances;
      logic                last;
   } anim_req_type;

   typedef struct {
      logic               status;
      logic               paused;
      logic               active;
      logic [POSE_W-1:0]  pose;
      logic [INDEX_W-1:0] xform;
      logic [INDEX_W-1:0] root;
   } anim_rsp_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // shadow of the instance table
   logic [COUNT_W-1:0]  group_offset[MAX_GROUPS];
   bit                  group_known[MAX_GROUPS];
   int                  countdown_tbl[MAX_ENTRIES];
   logic [FRAMES_W-1:0] reload_tbl[MAX_ENTRIES];
   logic [PCOUNT_W-1:0] poses_tbl[MAX_ENTRIES];
   logic [POSE_W-1:0]   pose_tbl[MAX_ENTRIES];
   logic [MESH_W-1:0]   mesh_tbl[MAX_ENTRIES];
   logic [INDEX_W-1:0]  xform_tbl[MAX_ENTRIES];
   logic [INDEX_W-1:0]  root_tbl[MAX_ENTRIES];
   bit                  has_pose_tbl[MAX_ENTRIES];
   bit                  entry_loaded[MAX_ENTRIES];
   int                  offset_acc;
   int                  group_cursor;
   int                  walk_total;

   anim_rsp_type expected_reports[$];

   int idle_pct = 20;
   int rsp_hold = 0;
   int n_errors = 0;
   int n_requests = 0;
   int n_checked = 0;
   int n_ticks = 0;
   int n_queries = 0;
   int n_builds = 0;
   int n_overflows = 0;

   keyframe_animation_sequencer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("%0t: timeout, %0d results outstanding", $time, expected_reports.size());
      $display("keyframe_animation_sequencer test failed");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic bit locate_entry(input logic [MODEL_W-1:0] m,
                                       input logic [INST_W-1:0] i, output int e);
      e = int'(group_offset[m]) + int'(i);
      return e < MAX_ENTRIES;
   endfunction

   function automatic void clear_table();
      for (int k = 0; k < MAX_ENTRIES; k++) begin
         countdown_tbl[k] = -1;
         has_pose_tbl[k]  = 1'b0;
      end
   endfunction

   function automatic void walk_entries();
      logic [POSE_W-1:0] lastp;
      for (int k = 0; k < walk_total; k++) begin
         if (countdown_tbl[k] == -1) continue;
         countdown_tbl[k]--;
         if (countdown_tbl[k] >= 0) continue;
         countdown_tbl[k] = int'(reload_tbl[k]);
         if (pose_tbl[k] == 0) begin
            // wrap to the last pose
            lastp = POSE_W'(poses_tbl[k] - 8'd1);
            pose_tbl[k]  = lastp;
            xform_tbl[k] = INDEX_W'(xform_tbl[k] + INDEX_W'(lastp) * INDEX_W'(mesh_tbl[k]));
            root_tbl[k]  = INDEX_W'(root_tbl[k] + INDEX_W'(lastp));
         end else begin
            pose_tbl[k]  = pose_tbl[k] - 8'd1;
            xform_tbl[k] = INDEX_W'(xform_tbl[k] - INDEX_W'(mesh_tbl[k]));
            root_tbl[k]  = INDEX_W'(root_tbl[k] - 16'd1);
         end
      end
   endfunction

   function automatic anim_rsp_type step_animation(input anim_req_type r);
      anim_rsp_type res;
      int e;
      logic [POSE_W-1:0] lastp;
      res = '{default: '0};
      case (r.command)
         CMD_START: begin
            if (locate_entry(r.model_id, r.inst, e)) begin
               lastp = POSE_W'(r.pose_count - 8'd1);
               countdown_tbl[e] = int'(r.frames);
               reload_tbl[e]    = r.frames;
               poses_tbl[e]     = r.pose_count;
               pose_tbl[e]      = lastp;
               mesh_tbl[e]      = r.mesh;
               root_tbl[e]      = INDEX_W'(r.pose_base + INDEX_W'(lastp));
               xform_tbl[e]     = INDEX_W'(r.transform_base
                                           + INDEX_W'(lastp) * INDEX_W'(r.mesh));
               has_pose_tbl[e]  = 1'b1;
               entry_loaded[e]  = 1'b1;
            end
         end
         CMD_PAUSE: begin
            if (locate_entry(r.model_id, r.inst, e)) countdown_tbl[e] = -1;
         end
         CMD_UNPAUSE: begin
            if (locate_entry(r.model_id, r.inst, e)) countdown_tbl[e] = int'(reload_tbl[e]);
         end
         CMD_DEACT: begin
            if (locate_entry(r.model_id, r.inst, e)) begin
               countdown_tbl[e] = -1;
               has_pose_tbl[e]  = 1'b0;
            end
         end
         CMD_TICK: begin
            walk_entries();
         end
         CMD_QUERY: begin
            if (locate_entry(r.model_id, r.inst, e)) begin
               res.paused = (countdown_tbl[e] == -1);
               res.active = has_pose_tbl[e];
               res.pose   = pose_tbl[e];
               res.xform  = xform_tbl[e];
               res.root   = root_tbl[e];
            end
         end
         CMD_SETCNT: begin
            group_offset[group_cursor] = (offset_acc > 127) ? 7'd127 : COUNT_W'(offset_acc);
            group_known[group_cursor]  = 1'b1;
            offset_acc = offset_acc + int'(r.instances);
            if (offset_acc > 255) offset_acc = 255;
            walk_total = (offset_acc > MAX_ENTRIES) ? MAX_ENTRIES : offset_acc;
            group_cursor = (group_cursor + 1) % MAX_GROUPS;
            if (r.last) begin
               res.status = (offset_acc >= MAX_ENTRIES);
               clear_table();
               offset_acc   = 0;
               group_cursor = 0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------ transfers

   function automatic logic [REQ_TDATA_W-1:0] pack_request(input anim_req_type r);
      logic [REQ_TDATA_W-1:0] d;
      d = '0;
      d[CMD_LSB    +: CMD_W]    = r.command;
      d[MODEL_LSB  +: MODEL_W]  = r.model_id;
      d[INST_LSB   +: INST_W]   = r.inst;
      d[FRAMES_LSB +: FRAMES_W] = r.frames;
      d[PCOUNT_LSB +: PCOUNT_W] = r.pose_count;
      d[PBASE_LSB  +: PBASE_W]  = r.pose_base;
      d[TBASE_LSB  +: TBASE_W]  = r.transform_base;
      d[MESH_LSB   +: MESH_W]   = r.mesh;
      d[COUNT_LSB  +: COUNT_W]  = r.instances;
      return d;
   endfunction

   task automatic send_request(input anim_req_type r);
      anim_rsp_type res;
      @(negedge clock);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_tdata  <= pack_request(r);
      req_tlast  <= r.last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      res = step_animation(r);
      expected_reports.push_back(res);
      n_requests++;
      if (r.command == CMD_TICK) n_ticks++;
      if (r.command == CMD_QUERY) n_queries++;
      if (r.command == CMD_SETCNT && r.last) begin
         n_builds++;
         if (res.status) n_overflows++;
      end
   endtask

   // receiver: random stalls, plus a counted hold-off when requested
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         n_errors++;
      end
   endtask

   task automatic check_report(input logic [RSP_TDATA_W-1:0] d);
      anim_rsp_type want;
      if (expected_reports.size() == 0) begin
         $display("%0t: result with none expected, expected nothing, actual %h", $time, d);
         n_errors++;
         return;
      end
      want = expected_reports.pop_front();
      n_checked++;
      compare_field("status", 16'(want.status), 16'(d[0]));
      compare_field("paused", 16'(want.paused), 16'(d[1]));
      compare_field("active", 16'(want.active), 16'(d[2]));
      compare_field("pose_now", 16'(want.pose), 16'(d[3 +: POSE_W]));
      compare_field("transform_index", want.xform, d[3 + POSE_W +: INDEX_W]);
      compare_field("root_index", want.root, d[3 + POSE_W + INDEX_W +: INDEX_W]);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_report(rsp_tdata);
   end

   // ------------------------------------------------------------- builders

   function automatic anim_req_type blank_req(input logic [CMD_W-1:0] cmd);
      anim_req_type r;
      r = '{default: '0};
      r.command = cmd;
      return r;
   endfunction

   function automatic anim_req_type random_req(input logic [CMD_W-1:0] cmd);
      anim_req_type r;
      r.command        = cmd;
      r.model_id       = MODEL_W'($urandom);
      r.inst           = INST_W'($urandom);
      r.frames         = FRAMES_W'($urandom);
      r.pose_count     = PCOUNT_W'($urandom);
      r.pose_base      = PBASE_W'($urandom);
      r.transform_base = TBASE_W'($urandom);
      r.mesh           = MESH_W'($urandom);
      r.instances      = COUNT_W'($urandom);
      r.last           = 1'($urandom);
      return r;
   endfunction

   task automatic send_count(input int count, input bit last);
      anim_req_type r;
      r = blank_req(CMD_SETCNT);
      r.instances = COUNT_W'(count);
      r.last = last;
      send_request(r);
   endtask

   task automatic send_addressed(input logic [CMD_W-1:0] cmd, input int m, input int i);
      anim_req_type r;
      r = blank_req(cmd);
      r.model_id = MODEL_W'(m);
      r.inst = INST_W'(i);
      send_request(r);
   endtask

   task automatic send_start(input int m, input int i, input int frames, input int pc,
                             input int pb, input int tb, input int mc);
      anim_req_type r;
      r = blank_req(CMD_START);
      r.model_id       = MODEL_W'(m);
      r.inst           = INST_W'(i);
      r.frames         = FRAMES_W'(frames);
      r.pose_count     = PCOUNT_W'(pc);
      r.pose_base      = PBASE_W'(pb);
      r.transform_base = TBASE_W'(tb);
      r.mesh           = MESH_W'(mc);
      send_request(r);
   endtask

   // aim at a group whose offset is known
   function automatic void aim_any(inout anim_req_type r);
      int m;
      do m = $urandom_range(0, MAX_GROUPS - 1); while (!group_known[m]);
      r.model_id = MODEL_W'(m);
      r.inst = ($urandom_range(0, 99) < 85) ? INST_W'($urandom_range(0, 7)) : INST_W'($urandom);
   endfunction

   // aim at an entry that was loaded by a start
   function automatic bit aim_loaded(inout anim_req_type r);
      int entries[$];
      int groups[$];
      int e;
      int m;
      for (int k = 0; k < MAX_ENTRIES; k++) if (entry_loaded[k]) entries.push_back(k);
      if (entries.size() == 0) return 1'b0;
      e = entries[$urandom_range(0, entries.size() - 1)];
      for (int g = 0; g < MAX_GROUPS; g++)
         if (group_known[g] && int'(group_offset[g]) <= e) groups.push_back(g);
      if (groups.size() == 0) return 1'b0;
      m = groups[$urandom_range(0, groups.size() - 1)];
      r.model_id = MODEL_W'(m);
      r.inst = INST_W'(e - int'(group_offset[m]));
      return 1'b1;
   endfunction

   // aim past the end of the table
   function automatic bit aim_outside(inout anim_req_type r);
      int groups[$];
      int m;
      for (int g = 0; g < MAX_GROUPS; g++)
         if (group_known[g] && group_offset[g] != 0) groups.push_back(g);
      if (groups.size() == 0) return 1'b0;
      m = groups[$urandom_range(0, groups.size() - 1)];
      r.model_id = MODEL_W'(m);
      r.inst = INST_W'($urandom_range(MAX_ENTRIES - int'(group_offset[m]), 63));
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_instance_groups();
      // overflowing build with two counts of 64
      send_count(64, 1'b0);
      send_count(64, 1'b1);
      // groups of 5, 0 and 3: offsets 0, 5, 5 and eight entries in all
      send_count(5, 1'b0);
      send_count(0, 1'b0);
      send_count(3, 1'b1);
   endtask

   task automatic test_start_and_query();
      send_start(0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 32);   // count of zero, indices wrap
      send_start(1, 2, 16'hFFFF, 255, 0, 0, 1);
      send_start(0, 1, 0, 2, 100, 200, 3);
      send_addressed(CMD_QUERY, 0, 0);
      send_addressed(CMD_QUERY, 1, 2);
      send_addressed(CMD_QUERY, 0, 1);
   endtask

   task automatic test_pose_stepping();
      // entry 1 steps down to pose zero, wraps to its last pose, steps down again
      repeat (3) send_addressed(CMD_TICK, 0, 0);
      send_addressed(CMD_QUERY, 0, 1);
      send_addressed(CMD_QUERY, 0, 0);
   endtask

   task automatic test_pause_controls();
      send_addressed(CMD_PAUSE, 0, 0);
      send_addressed(CMD_TICK, 0, 0);
      send_addressed(CMD_QUERY, 0, 0);
      send_addressed(CMD_UNPAUSE, 0, 0);
      send_addressed(CMD_DEACT, 0, 1);
      send_addressed(CMD_QUERY, 0, 1);
      // unpause of an inactive entry still reloads its countdown
      send_addressed(CMD_UNPAUSE, 0, 1);
      send_addressed(CMD_QUERY, 0, 1);
   endtask

   task automatic test_out_of_range();
      send_start(2, 63, 1, 4, 7, 9, 2);
      send_addressed(CMD_PAUSE, 2, 62);
      send_addressed(CMD_QUERY, 2, 63);
   endtask

   task automatic test_unused_command();
      send_request(random_req(CMD_UNUSED));
   endtask

   task automatic test_backpressure();
      anim_req_type r;
      rsp_hold = 300;
      for (int n = 0; n < 12; n++) begin
         r = random_req(CMD_QUERY);
         if (!aim_loaded(r)) r.command = CMD_TICK;
         send_request(r);
      end
   endtask

   task automatic run_scene(input bit wide_counts, input bit broken);
      anim_req_type r;
      int groups;
      int ops;
      int pick;
      groups = ($urandom_range(0, 99) < 15) ? $urandom_range(17, 20) : $urandom_range(1, 16);
      for (int g = 0; g < groups; g++) begin
         r = random_req(CMD_SETCNT);
         if (!wide_counts) r.instances = COUNT_W'($urandom_range(0, 8));
         r.last = (g == groups - 1) && !broken;
         send_request(r);
      end
      ops = $urandom_range(30, 70);
      for (int n = 0; n < ops; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 22) begin
            r = random_req(CMD_START);
            aim_any(r);
            if ($urandom_range(0, 99) < 80) r.frames = FRAMES_W'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 80) r.pose_count = PCOUNT_W'($urandom_range(1, 4));
         end else if (pick < 40 || pick >= 92) begin
            r = random_req(CMD_TICK);
         end else if (pick < 65) begin
            r = random_req(CMD_QUERY);
            if ($urandom_range(0, 99) < 15) begin
               if (!aim_outside(r) && !aim_loaded(r)) r.command = CMD_TICK;
            end else if (!aim_loaded(r)) begin
               r.command = CMD_START;
               aim_any(r);
            end
         end else if (pick < 72) begin
            r = random_req(CMD_PAUSE);
            aim_any(r);
         end else if (pick < 79) begin
            r = random_req(CMD_UNPAUSE);
            if (!aim_loaded(r)) r.command = CMD_PAUSE;
         end else if (pick < 86) begin
            r = random_req(CMD_DEACT);
            aim_any(r);
         end else if (pick < 89) begin
            r = random_req(CMD_UNUSED);
         end else begin
            // stray count item outside a build
            r = random_req(CMD_SETCNT);
            r.instances = COUNT_W'($urandom_range(0, 8));
            r.last = 1'b0;
         end
         send_request(r);
      end
   endtask

   task automatic test_random_scenes();
      int first;
      int scene;
      first = n_requests;
      scene = 0;
      while (n_requests - first < RANDOM_REQS) begin
         // one stretch with no idling on either side
         idle_pct = (scene == 4) ? 0 : 20;
         run_scene($urandom_range(0, 99) < 12, $urandom_range(0, 99) < 10);
         scene++;
      end
      idle_pct = 20;
   endtask

   initial begin
      offset_acc   = 0;
      group_cursor = 0;
      walk_total   = 0;
      clear_table();
      for (int k = 0; k < MAX_ENTRIES; k++) entry_loaded[k] = 1'b0;
      for (int g = 0; g < MAX_GROUPS; g++) group_known[g] = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_instance_groups();
      test_start_and_query();
      test_pose_stepping();
      test_pause_controls();
      test_out_of_range();
      test_unused_command();
      test_backpressure();
      test_random_scenes();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Covered %0d requests: %0d ticks, %0d queries, %0d group builds (%0d overflowed)",
               n_requests, n_ticks, n_queries, n_builds, n_overflows);
      $display("Compared %0d responses, %0d mismatches", n_checked, n_errors);
      if (n_errors == 0 && expected_reports.size() == 0) begin
         $display("keyframe_animation_sequencer test passed");
      end else begin
         $display("keyframe_animation_sequencer test failed");
      end
      $finish;
   end

endmodule
